[hdl/stmin_pkg.sv]
`timescale 1ns / 1ps

package stmin_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int VAL_W    = 32;
	localparam int CNT_W    = IDX_W + 1;
	localparam int NODE_AW  = IDX_W + 1;
	localparam int ST_W     = 2;

	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(CAPACITY);

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	// One tree node: the minimum over its span and the leftmost index holding it.
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic        [IDX_W-1:0] index;
	} node_t;

	typedef struct packed {
		logic                    func;
		logic        [IDX_W-1:0] point_index;
		logic signed [VAL_W-1:0] write_value;
		logic        [IDX_W-1:0] range_low;
		logic        [IDX_W-1:0] range_high;
	} item_t;

	typedef struct packed {
		logic        [IDX_W-1:0] min_index;
		logic signed [VAL_W-1:0] min_value;
		logic        [ST_W-1:0]  status;
	} result_t;

	// Smaller value wins, equal values go to the lower index.
	function automatic node_t pick_min(input node_t a, input node_t b);
		if ((a.value < b.value) || ((a.value == b.value) && (a.index <= b.index)))
			return a;
		return b;
	endfunction

endpackage

[hdl/stmin_apb.sv]
`timescale 1ns / 1ps

module stmin_apb import stmin_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [CNT_W-1:0] element_count
);

	localparam logic REG_ELEMENT_COUNT = 1'b0;

	logic [CNT_W-1:0] element_count_q;
	logic             wr_en;

	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= COUNT_RESET;
		end else if (wr_en) begin
			element_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ELEMENT_COUNT)
			prdata = 32'(element_count_q);
	end

	assign element_count = element_count_q;

endmodule

[hdl/stmin_engine.sv]
`timescale 1ns / 1ps

module stmin_engine import stmin_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  item_t            item,
	input  logic [CNT_W-1:0] element_count,
	output logic             busy,
	output logic             done,
	output result_t          result
);

	localparam int QB_W = NODE_AW + 1;
	localparam int NODES = 2 * CAPACITY;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_UPD   = 2'd2;
	localparam logic [1:0] S_QRY   = 2'd3;

	// Heap-ordered tree: root at 1, leaf of entry i at CAPACITY + i.
	node_t mem [NODES];

	logic [1:0]         state_q;
	logic [NODE_AW-1:0] clr_q;
	logic [NODE_AW-1:0] node_q;
	node_t              acc_q;
	logic [QB_W-1:0]    l_q;
	logic [QB_W-1:0]    r_q;
	logic               tk_a_s1;
	logic               tk_b_s1;
	node_t              pair_s2;
	logic               pair_v_s2;
	node_t              qacc_q;
	logic               have_q;
	logic               done_q;
	result_t            result_q;
	node_t              rd_a_q;
	node_t              rd_b_q;

	logic               mem_we;
	logic [NODE_AW-1:0] mem_wa;
	node_t              mem_wd;
	logic [NODE_AW-1:0] mem_ra;
	logic [NODE_AW-1:0] mem_rb;

	logic [CNT_W-1:0]   count_live;
	logic [CNT_W-1:0]   count_last;
	logic [CNT_W-1:0]   qhi_ext;
	logic [CNT_W-1:0]   qhi_clip;
	logic               accept;
	logic               upd_ok;
	logic               qry_ok;
	logic [NODE_AW-1:0] leaf;
	logic [NODE_AW-1:0] parent;
	node_t              upd_comb;
	node_t              leaf_node;
	logic               lt;
	logic [QB_W-1:0]    l_next;
	logic [QB_W-1:0]    r_next;
	node_t              pair_comb;
	logic               qry_drained;

	// First leaf index under a node: shift the node up to leaf depth.
	function automatic logic [IDX_W-1:0] first_index(input logic [NODE_AW-1:0] n);
		logic [IDX_W-1:0] f;
		f = '0;
		for (int i = 0; i < NODE_AW; i++) begin
			if (n[i])
				f = IDX_W'(n << (NODE_AW - 1 - i));
		end
		return f;
	endfunction

	always_comb begin
		count_live = (element_count > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : element_count;
		count_last = count_live - CNT_W'(1);
		qhi_ext    = CNT_W'(item.range_high);
		qhi_clip   = (qhi_ext > count_last) ? count_last : qhi_ext;
		accept     = start && (state_q == S_IDLE);
		upd_ok     = CNT_W'(item.point_index) < count_live;
		qry_ok     = (count_live != '0) && (CNT_W'(item.range_low) <= qhi_clip);
		leaf       = NODE_AW'(CAPACITY) + NODE_AW'(item.point_index);
		leaf_node  = '{value: item.write_value, index: item.point_index};
		parent     = node_q >> 1;
		upd_comb   = pick_min(acc_q, rd_a_q);
		lt         = l_q < r_q;
		l_next     = (l_q + QB_W'(l_q[0])) >> 1;
		r_next     = r_q >> 1;
		qry_drained = !lt && !tk_a_s1 && !tk_b_s1 && !pair_v_s2;
		if (tk_a_s1 && tk_b_s1)
			pair_comb = pick_min(rd_a_q, rd_b_q);
		else if (tk_a_s1)
			pair_comb = rd_a_q;
		else
			pair_comb = rd_b_q;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_ra = '0;
		mem_rb = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '{value: '0, index: first_index(clr_q)};
			end
			S_IDLE: begin
				if (accept && (item.func == FUNC_UPDATE) && upd_ok) begin
					mem_we = 1'b1;
					mem_wa = leaf;
					mem_wd = leaf_node;
					mem_ra = leaf ^ NODE_AW'(1);
				end
			end
			S_UPD: begin
				mem_we = 1'b1;
				mem_wa = parent;
				mem_wd = upd_comb;
				mem_ra = parent ^ NODE_AW'(1);
			end
			S_QRY: begin
				mem_ra = l_q[NODE_AW-1:0];
				mem_rb = r_q[NODE_AW-1:0] - NODE_AW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_a_q <= mem[mem_ra];
		rd_b_q <= mem[mem_rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			node_q    <= '0;
			acc_q     <= '0;
			l_q       <= '0;
			r_q       <= '0;
			tk_a_s1   <= 1'b0;
			tk_b_s1   <= 1'b0;
			pair_s2   <= '0;
			pair_v_s2 <= 1'b0;
			qacc_q    <= '0;
			have_q    <= 1'b0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q    <= 1'b0;
			tk_a_s1   <= (state_q == S_QRY) && lt && l_q[0];
			tk_b_s1   <= (state_q == S_QRY) && lt && r_q[0];
			pair_s2   <= pair_comb;
			pair_v_s2 <= tk_a_s1 || tk_b_s1;
			if (pair_v_s2) begin
				qacc_q <= have_q ? pick_min(qacc_q, pair_s2) : pair_s2;
				have_q <= 1'b1;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NODE_AW'(1);
					if (&clr_q)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (item.func == FUNC_UPDATE) begin
							if (upd_ok) begin
								node_q  <= leaf;
								acc_q   <= leaf_node;
								state_q <= S_UPD;
							end else begin
								done_q   <= 1'b1;
								result_q <= '{min_index: '0, min_value: '0, status: ST_RANGE};
							end
						end else begin
							if (qry_ok) begin
								l_q     <= QB_W'(item.range_low) + QB_W'(CAPACITY);
								r_q     <= QB_W'(qhi_clip) + QB_W'(CAPACITY) + QB_W'(1);
								have_q  <= 1'b0;
								state_q <= S_QRY;
							end else begin
								done_q   <= 1'b1;
								result_q <= '{min_index: '0, min_value: '0, status: ST_EMPTY};
							end
						end
					end
				end
				S_UPD: begin
					node_q <= parent;
					acc_q  <= upd_comb;
					// Root written: report the minimum over the live entries.
					if (parent == NODE_AW'(1)) begin
						l_q     <= QB_W'(CAPACITY);
						r_q     <= QB_W'(count_live) + QB_W'(CAPACITY);
						have_q  <= 1'b0;
						state_q <= S_QRY;
					end
				end
				S_QRY: begin
					if (lt) begin
						l_q <= l_next;
						r_q <= r_next;
					end else if (qry_drained) begin
						done_q   <= 1'b1;
						result_q <= '{min_index: qacc_q.index, min_value: qacc_q.value,
							status: ST_OK};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

[hdl/segment_tree_range_min_core.sv]
`timescale 1ns / 1ps

// Range-minimum store with point update. An item is taken at a clock edge with
// start high and busy low; its result appears for exactly one cycle with done
// high and must be captured then, since the block has no way to hold it. A
// query climbs the tree one level per cycle through the dual-read tree memory.
// An update first repairs its leaf-to-root path, one level per cycle with a
// read of the sibling and a write of the parent, then runs the query over all
// live entries. An empty query or an update past element_count is answered
// in the cycle after it is taken. After reset the block clears every node of
// the tree memory with busy high; configuration writes are taken during that
// pass.
module segment_tree_range_min_core import stmin_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    start,
	output logic                    busy,
	input  logic                    func,
	input  logic        [IDX_W-1:0] point_index,
	input  logic signed [VAL_W-1:0] write_value,
	input  logic        [IDX_W-1:0] range_low,
	input  logic        [IDX_W-1:0] range_high,
	output logic                    done,
	output logic        [IDX_W-1:0] min_index,
	output logic signed [VAL_W-1:0] min_value,
	output logic        [ST_W-1:0]  status
);

	logic [CNT_W-1:0] element_count;
	item_t            item;
	result_t          result;

	assign item = '{func: func, point_index: point_index, write_value: write_value,
		range_low: range_low, range_high: range_high};

	stmin_apb u_apb (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.element_count (element_count)
	);

	stmin_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.item          (item),
		.element_count (element_count),
		.busy          (busy),
		.done          (done),
		.result        (result)
	);

	assign min_index = result.min_index;
	assign min_value = result.min_value;
	assign status    = result.status;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb import stmin_pkg::*; ();

	localparam logic [2:0] REG_ELEMENT_COUNT = 3'd0;
	localparam int         DRAIN_CYCLES      = 30;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    psel        = 1'b0;
	logic                    penable     = 1'b0;
	logic                    pwrite      = 1'b0;
	logic [2:0]              paddr       = '0;
	logic [31:0]             pwdata      = '0;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    start       = 1'b0;
	logic                    busy;
	logic                    func        = FUNC_UPDATE;
	logic        [IDX_W-1:0] point_index = '0;
	logic signed [VAL_W-1:0] write_value = '0;
	logic        [IDX_W-1:0] range_low   = '0;
	logic        [IDX_W-1:0] range_high  = '0;
	logic                    done;
	logic        [IDX_W-1:0] min_index;
	logic signed [VAL_W-1:0] min_value;
	logic        [ST_W-1:0]  status;

	// shadow copy of the array and of the count register
	logic signed [VAL_W-1:0] shadow_values [CAPACITY];
	logic [CNT_W-1:0]        shadow_count;

	item_t   pending_items[$];
	result_t expected_results[$];
	item_t   offered;
	result_t next_result;
	int      gap_pct;
	int      errors;
	int      n_checked, n_updates, n_queries, n_empty, n_range, n_settings;

	segment_tree_range_min_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.point_index(point_index),
		.write_value(write_value),
		.range_low  (range_low),
		.range_high (range_high),
		.done       (done),
		.min_index  (min_index),
		.min_value  (min_value),
		.status     (status)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("tb: failure");
		$finish;
	end

	// Apply one item to the shadow store and return the answer it should give.
	function automatic result_t apply_item(input item_t it);
		result_t res;
		int      live, lo, hi, best;
		live = (shadow_count > CAPACITY) ? CAPACITY : int'(shadow_count);
		res = '0;
		res.status = ST_OK;
		lo = 0;
		hi = live - 1;
		if (it.func == FUNC_UPDATE) begin
			if (int'(it.point_index) >= live) begin
				res.status = ST_RANGE;
			end else begin
				shadow_values[it.point_index] = it.write_value;
			end
		end else begin
			lo = int'(it.range_low);
			if (int'(it.range_high) < hi)
				hi = int'(it.range_high);
			if (live == 0 || lo > hi)
				res.status = ST_EMPTY;
		end
		if (res.status == ST_OK) begin
			best = lo;
			for (int i = lo + 1; i <= hi; i++)
				if (shadow_values[i] < shadow_values[best])
					best = i;
			res.min_index = IDX_W'(best);
			res.min_value = shadow_values[best];
		end
		return res;
	endfunction

	function automatic item_t update_item(input int pos, input logic [31:0] val);
		item_t it;
		it = '0;
		it.func        = FUNC_UPDATE;
		it.point_index = IDX_W'(pos);
		it.write_value = val;
		it.range_low   = IDX_W'($urandom);
		it.range_high  = IDX_W'($urandom);
		return it;
	endfunction

	function automatic item_t query_item(input int lo, input int hi);
		item_t it;
		it = '0;
		it.func        = FUNC_QUERY;
		it.point_index = IDX_W'($urandom);
		it.write_value = $urandom;
		it.range_low   = IDX_W'(lo);
		it.range_high  = IDX_W'(hi);
		return it;
	endfunction

	// append an item to the driver's queue
	function automatic void add_item(input item_t it);
		pending_items = {pending_items, it};
	endfunction

	// Mostly in-range indices and narrow value spread, so ties and repairs happen often.
	function automatic item_t random_item(input int live);
		logic [31:0] val;
		int          lim, pos, lo, hi;
		lim = (live > 0) ? live - 1 : 0;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: val = 32'($signed($urandom_range(16)) - 8);
			5, 6, 7:       val = $urandom;
			8:             val = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default:       val = $urandom_range(1) ? 32'h3f3f_3f3f : 32'hffff_ffff;
		endcase
		pos = ($urandom_range(9) < 8) ? $urandom_range(lim) : $urandom_range(CAPACITY - 1);
		lo  = ($urandom_range(9) < 8) ? $urandom_range(lim) : $urandom_range(CAPACITY - 1);
		case ($urandom_range(3))
			0:       hi = lo + $urandom_range(15);
			1:       hi = $urandom_range(CAPACITY - 1);
			2:       hi = lo + $urandom_range(lim);
			default: hi = $urandom_range(lim);
		endcase
		if (hi > CAPACITY - 1)
			hi = CAPACITY - 1;
		if ($urandom_range(1))
			return update_item(pos, val);
		return query_item(lo, hi);
	endfunction

	task automatic set_count(input logic [CNT_W-1:0] count);
		logic [31:0] word;
		word = $urandom;
		word[CNT_W-1:0] = count;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ELEMENT_COUNT;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		shadow_count = count;
		n_settings++;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {{(32 - CNT_W){1'b0}}, count}) begin
			$error("element_count: expected %0d, got %0d", count, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || start || expected_results.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic random_phase(input int count, input int pct, input int n);
		int live;
		wait_idle();
		set_count(CNT_W'(count));
		live = (count > CAPACITY) ? CAPACITY : count;
		gap_pct = pct;
		repeat (n)
			add_item(random_item(live));
	endtask

	// driver: hold an item until the block takes it, then offer the next
	always @(posedge clk) begin
		if (start && !busy) begin
			next_result = apply_item(offered);
			expected_results = {expected_results, next_result};
			if (offered.func == FUNC_UPDATE)
				n_updates++;
			else
				n_queries++;
			if (next_result.status == ST_EMPTY)
				n_empty++;
			if (next_result.status == ST_RANGE)
				n_range++;
		end
		if (!start || !busy) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
				offered = pending_items.pop_front();
				start       <= 1'b1;
				func        <= offered.func;
				point_index <= offered.point_index;
				write_value <= offered.write_value;
				range_low   <= offered.range_low;
				range_high  <= offered.range_high;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: results cannot be held off, so take one whenever done is high
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no item outstanding: index %0d value %0d status %0d",
					min_index, min_value, status);
				errors++;
			end else begin
				result_t want;
				want = expected_results.pop_front();
				n_checked++;
				if (min_index !== want.min_index) begin
					$error("min_index: expected %0d, got %0d", want.min_index, min_index);
					errors++;
				end
				if (min_value !== want.min_value) begin
					$error("min_value: expected %0d, got %0d", want.min_value, min_value);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		gap_pct = 0;
		n_checked = 0;
		n_updates = 0;
		n_queries = 0;
		n_empty = 0;
		n_range = 0;
		n_settings = 0;
		shadow_count = COUNT_RESET;
		foreach (shadow_values[i])
			shadow_values[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// full array: extremes, ties, single-entry and reversed ranges
		set_count(COUNT_RESET);
		add_item(query_item(0, 1023));
		add_item(update_item(1023, 32'h7fff_ffff));
		add_item(update_item(0, 32'h8000_0000));
		add_item(query_item(1, 1023));
		add_item(update_item(512, 32'hffff_ffff));
		add_item(query_item(1, 1023));
		add_item(update_item(300, 32'hffff_ffff));
		add_item(query_item(1, 1023));
		add_item(query_item(513, 1023));
		add_item(query_item(1023, 1023));
		add_item(query_item(700, 3));
		add_item(update_item(0, 32'h3f3f_3f3f));
		add_item(update_item(1023, 32'h8000_0000));
		add_item(query_item(0, 1022));
		add_item(query_item(5, 5));
		wait_idle();

		// short array: clipped ends, empty ranges, updates past the count
		set_count(CNT_W'(10));
		add_item(update_item(10, 32'd5));
		add_item(update_item(9, 32'hffff_fff9));
		add_item(query_item(3, 1023));
		add_item(query_item(12, 20));
		add_item(query_item(10, 10));
		wait_idle();

		set_count('0);
		add_item(query_item(0, 0));
		add_item(update_item(0, 32'd1));
		wait_idle();

		// count above capacity; entries hidden by the short count come back
		set_count('1);
		add_item(update_item(1023, 32'd5));
		add_item(query_item(1000, 1023));
		add_item(query_item(0, 1023));

		random_phase(1024, 0, 300);
		random_phase(16, 48, 200);
		random_phase(1, 21, 100);
		random_phase(2047, 48, 250);
		random_phase(0, 0, 50);
		random_phase(700, 21, 250);
		random_phase(1024, 0, 150);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d results over %0d count settings: %0d updates, %0d queries",
			n_checked, n_settings, n_updates, n_queries);
		$display("of these %0d empty ranges and %0d updates past the count, %0d errors",
			n_empty, n_range, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
